FILE: sv/wir_pkg.sv
// Shared types, constants and helper functions of the windowed image rotator.
// Used by every module of the block but wir_ram; depends on nothing.
`default_nettype none

package wir_pkg;

    localparam int FRAME_WIDTH    = 512;
    localparam int FRAME_HEIGHT   = 512;
    localparam int TRIG_FRAC_BITS = 14;

    localparam int POS_W   = 9;
    localparam int DIFF_W  = POS_W + 1;
    localparam int TRIG_W  = 16;
    localparam int CTR_W   = 9;
    localparam int WIN_W   = 10;
    localparam int PIXEL_W = 24;
    localparam int SRC_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int PROD_W  = DIFF_W + TRIG_W;
    localparam int CTERM_W = CTR_W + 1 + TRIG_FRAC_BITS;
    localparam int SUM_W   = ((PROD_W > CTERM_W) ? PROD_W : CTERM_W) + 2;
    localparam int ADDR_W  = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
    localparam int FRAME_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;

    localparam int SRC_MIN = -1024;
    localparam int SRC_MAX = 2047;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COS          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BOT   = 3'd7;

    localparam logic signed [TRIG_W-1:0] COS_RESET   = 16'sh4000;
    localparam logic [WIN_W-1:0]         RIGHT_RESET = 10'd512;
    localparam logic [WIN_W-1:0]         BOTTOM_RESET = 10'd512;

    typedef struct packed {
        logic               is_load;
        logic               hit;
        logic               wr_flag;
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] pixel;
        logic [SRC_W-1:0]   src_x;
        logic [SRC_W-1:0]   src_y;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [ADDR_W-1:0] frame_addr(input logic [31:0] col,
                                                     input logic [31:0] row);
        logic [ADDR_W-1:0] w;
        w = ADDR_W'(FRAME_WIDTH);
        return ADDR_W'(row) * w + ADDR_W'(col);
    endfunction

    function automatic logic [SRC_W-1:0] clamp_src(input logic signed [31:0] v);
        logic [SRC_W-1:0] r;
        if (v < SRC_MIN)
            r = SRC_W'(SRC_MIN);
        else if (v > SRC_MAX)
            r = SRC_W'(SRC_MAX);
        else
            r = v[SRC_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/wir_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`default_nettype none

module wir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire                      rd_en,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/wir_front.sv
// Front part: configuration registers, input acceptance, window check and the
// two-stage inverse rotation pipeline that fills the work queue. Uses wir_pkg.
`default_nettype none

module wir_front (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire  [wir_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [wir_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                in_kind,
    input  wire  [wir_pkg::POS_W-1:0]          in_x,
    input  wire  [wir_pkg::POS_W-1:0]          in_y,
    input  wire  [wir_pkg::PIXEL_W-1:0]        in_pixel,
    input  wir_pkg::queue_stat_t               q_stat,
    output logic                               q_push,
    output wir_pkg::entry_t                    q_entry
);

    logic signed [wir_pkg::TRIG_W-1:0] cos_reg, sin_reg;
    logic [wir_pkg::CTR_W-1:0]         center_x_reg, center_y_reg;
    logic [wir_pkg::WIN_W-1:0]         left_reg, top_reg, right_reg, bottom_reg;

    logic                              a_valid_reg, b_valid_reg;
    logic                              a_kind_reg, b_kind_reg;
    logic [wir_pkg::POS_W-1:0]         a_x_reg, a_y_reg, b_x_reg, b_y_reg;
    logic [wir_pkg::PIXEL_W-1:0]       a_pixel_reg, b_pixel_reg;
    logic                              a_win_reg, b_win_reg;
    logic                              a_ldok_reg, b_ldok_reg;
    logic signed [wir_pkg::DIFF_W-1:0] a_dx_reg, a_dy_reg;
    logic signed [wir_pkg::PROD_W-1:0] b_xc_reg, b_ys_reg, b_yc_reg, b_xs_reg;

    logic                              advance;
    logic                              win_ok, in_win, load_ok;
    logic signed [wir_pkg::DIFF_W-1:0] dx_next, dy_next;
    logic signed [wir_pkg::PROD_W-1:0] dx_ext, dy_ext, cos_ext, sin_ext;
    logic signed [wir_pkg::SUM_W-1:0]  cx_term, cy_term, half_term;
    logic signed [wir_pkg::SUM_W-1:0]  sum_x, sum_y, shift_x, shift_y;
    logic signed [31:0]                src_col, src_row;
    logic                              in_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg      <= wir_pkg::COS_RESET;
            sin_reg      <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
            left_reg     <= '0;
            top_reg      <= '0;
            right_reg    <= wir_pkg::RIGHT_RESET;
            bottom_reg   <= wir_pkg::BOTTOM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wir_pkg::REG_COS:          cos_reg      <= cfg_data;
                wir_pkg::REG_SIN:          sin_reg      <= cfg_data;
                wir_pkg::REG_CENTER_X:     center_x_reg <= cfg_data[wir_pkg::CTR_W-1:0];
                wir_pkg::REG_CENTER_Y:     center_y_reg <= cfg_data[wir_pkg::CTR_W-1:0];
                wir_pkg::REG_WINDOW_LEFT:  left_reg     <= cfg_data[wir_pkg::WIN_W-1:0];
                wir_pkg::REG_WINDOW_TOP:   top_reg      <= cfg_data[wir_pkg::WIN_W-1:0];
                wir_pkg::REG_WINDOW_RIGHT: right_reg    <= cfg_data[wir_pkg::WIN_W-1:0];
                wir_pkg::REG_WINDOW_BOT:   bottom_reg   <= cfg_data[wir_pkg::WIN_W-1:0];
                default:                   cos_reg      <= cos_reg;
            endcase
        end
    end

    // Whole pipeline moves together; hold when the queue is full and stage b holds an entry
    assign advance  = !b_valid_reg || !q_stat.full;
    assign in_ready = advance;
    assign q_push   = b_valid_reg && !q_stat.full;

    assign win_ok  = (32'(left_reg) <= wir_pkg::FRAME_WIDTH)
                  && (32'(right_reg) <= wir_pkg::FRAME_WIDTH)
                  && (32'(top_reg) <= wir_pkg::FRAME_HEIGHT)
                  && (32'(bottom_reg) <= wir_pkg::FRAME_HEIGHT);
    assign in_win  = ({1'b0, in_x} >= left_reg) && ({1'b0, in_x} < right_reg)
                  && ({1'b0, in_y} >= top_reg) && ({1'b0, in_y} < bottom_reg);
    assign load_ok = (32'(in_x) < wir_pkg::FRAME_WIDTH)
                  && (32'(in_y) < wir_pkg::FRAME_HEIGHT);
    assign dx_next = $signed({1'b0, in_x}) - $signed({1'b0, center_x_reg});
    assign dy_next = $signed({1'b0, in_y}) - $signed({1'b0, center_y_reg});

    assign dx_ext  = wir_pkg::PROD_W'(a_dx_reg);
    assign dy_ext  = wir_pkg::PROD_W'(a_dy_reg);
    assign cos_ext = wir_pkg::PROD_W'(cos_reg);
    assign sin_ext = wir_pkg::PROD_W'(sin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_kind_reg  <= in_kind;
            a_x_reg     <= in_x;
            a_y_reg     <= in_y;
            a_pixel_reg <= in_pixel;
            a_win_reg   <= win_ok && in_win;
            a_ldok_reg  <= load_ok;
            a_dx_reg    <= dx_next;
            a_dy_reg    <= dy_next;
            b_kind_reg  <= a_kind_reg;
            b_x_reg     <= a_x_reg;
            b_y_reg     <= a_y_reg;
            b_pixel_reg <= a_pixel_reg;
            b_win_reg   <= a_win_reg;
            b_ldok_reg  <= a_ldok_reg;
            b_xc_reg    <= dx_ext * cos_ext;
            b_ys_reg    <= dy_ext * sin_ext;
            b_yc_reg    <= dy_ext * cos_ext;
            b_xs_reg    <= dx_ext * sin_ext;
        end
    end

    assign cx_term   = wir_pkg::SUM_W'(center_x_reg) << wir_pkg::TRIG_FRAC_BITS;
    assign cy_term   = wir_pkg::SUM_W'(center_y_reg) << wir_pkg::TRIG_FRAC_BITS;
    assign half_term = wir_pkg::SUM_W'(1) << (wir_pkg::TRIG_FRAC_BITS - 1);
    assign sum_x     = wir_pkg::SUM_W'(b_xc_reg) + wir_pkg::SUM_W'(b_ys_reg)
                     + cx_term + half_term;
    assign sum_y     = wir_pkg::SUM_W'(b_yc_reg) - wir_pkg::SUM_W'(b_xs_reg)
                     + cy_term + half_term;
    assign shift_x   = sum_x >>> wir_pkg::TRIG_FRAC_BITS;
    assign shift_y   = sum_y >>> wir_pkg::TRIG_FRAC_BITS;
    assign src_col   = 32'(shift_x);
    assign src_row   = 32'(shift_y);
    assign in_frame  = (src_col >= 0) && (src_col < wir_pkg::FRAME_WIDTH)
                    && (src_row >= 0) && (src_row < wir_pkg::FRAME_HEIGHT);

    always_comb
    begin
        q_entry = '0;
        if (b_kind_reg == wir_pkg::KIND_LOAD)
        begin
            q_entry.is_load = 1'b1;
            q_entry.hit     = b_ldok_reg;
            q_entry.addr    = wir_pkg::frame_addr(32'(b_x_reg), 32'(b_y_reg));
            q_entry.pixel   = b_pixel_reg;
        end
        else
        begin
            q_entry.hit     = in_frame;
            q_entry.wr_flag = in_frame && b_win_reg;
            q_entry.addr    = wir_pkg::frame_addr(src_col, src_row);
            q_entry.src_x   = wir_pkg::clamp_src(src_col);
            q_entry.src_y   = wir_pkg::clamp_src(src_row);
        end
    end

endmodule

`default_nettype wire

FILE: sv/wir_queue.sv
// Short register queue between the front and back parts.
// Uses wir_pkg for the entry type and depth.
`default_nettype none

module wir_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  wir_pkg::entry_t       push_entry,
    input  wire                   pop,
    output wir_pkg::entry_t       head,
    output wir_pkg::queue_stat_t  stat
);

    wir_pkg::entry_t                 slots [wir_pkg::QUEUE_DEPTH];
    logic [wir_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [wir_pkg::QCNT_W-1:0]      count_reg, count_next;

    function automatic logic [wir_pkg::QPTR_W-1:0] bump(
        input logic [wir_pkg::QPTR_W-1:0] p);
        logic [wir_pkg::QPTR_W-1:0] r;
        if (p == wir_pkg::QPTR_W'(wir_pkg::QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign stat.full  = (count_reg == wir_pkg::QCNT_W'(wir_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: sv/wir_back.sv
// Back part: drains the queue, writes loads into the frame memory, reads the
// source pixel for requests and holds the result for the output. Uses wir_pkg, wir_ram.
`default_nettype none

module wir_back (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wir_pkg::entry_t               head,
    input  wir_pkg::queue_stat_t          q_stat,
    output logic                          pop,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [wir_pkg::PIXEL_W-1:0]   out_pixel,
    output logic                          out_we,
    output logic [wir_pkg::SRC_W-1:0]     out_sx,
    output logic [wir_pkg::SRC_W-1:0]     out_sy
);

    logic                          mem_valid_reg;
    logic                          mem_hit_reg, mem_wr_reg;
    logic [wir_pkg::SRC_W-1:0]     mem_sx_reg, mem_sy_reg;
    logic                          out_valid_reg;
    logic [wir_pkg::PIXEL_W-1:0]   out_pixel_reg;
    logic                          out_we_reg;
    logic [wir_pkg::SRC_W-1:0]     out_sx_reg, out_sy_reg;

    logic                          mem_move, mem_free;
    logic                          ram_we, ram_re;
    logic [wir_pkg::PIXEL_W-1:0]   ram_rdata;

    assign mem_move = mem_valid_reg && (!out_valid_reg || out_ready);
    assign mem_free = !mem_valid_reg || mem_move;
    assign pop      = !q_stat.empty && (head.is_load || mem_free);
    assign ram_we   = pop && head.is_load && head.hit;
    assign ram_re   = pop && !head.is_load && head.hit;

    wir_ram #(
        .WIDTH (wir_pkg::PIXEL_W),
        .DEPTH (wir_pkg::FRAME_DEPTH)
    ) u_frame (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (head.addr),
        .wr_data (head.pixel),
        .rd_en   (ram_re),
        .rd_addr (head.addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && !head.is_load)
                mem_valid_reg <= 1'b1;
            else if (mem_move)
                mem_valid_reg <= 1'b0;
            if (mem_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !head.is_load)
        begin
            mem_hit_reg <= head.hit;
            mem_wr_reg  <= head.wr_flag;
            mem_sx_reg  <= head.src_x;
            mem_sy_reg  <= head.src_y;
        end
        if (mem_move)
        begin
            out_pixel_reg <= mem_hit_reg ? ram_rdata : '0;
            out_we_reg    <= mem_wr_reg;
            out_sx_reg    <= mem_sx_reg;
            out_sy_reg    <= mem_sy_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_we    = out_we_reg;
    assign out_sx    = out_sx_reg;
    assign out_sy    = out_sy_reg;

endmodule

`default_nettype wire

FILE: sv/windowed_image_rotator_top.sv
// Top level of the windowed image rotator: front pipeline, queue, back part.
// Uses wir_pkg, wir_front, wir_queue, wir_back.
//
//   Channel   Direction  Handshake            Contents
//   s_*       in         s_tvalid/s_tready    load or request word
//   m_*       out        m_tvalid/m_tready    fetched pixel, flag, source coordinates
//   cfg_*     in         cfg_we               register write, no read-back
//
// One word per clock while s_tready is high; after its word is taken, a request result
// passes two arithmetic stages, the queue, the memory read and the output register.
// Loads give no result and take one memory write slot each.
// Reset clears control state only; frame memory contents stay undefined.
// A four-entry queue absorbs output stalls; s_tready drops when it fills.
`default_nettype none

module windowed_image_rotator_top (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire  [wir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [wir_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [47:0]                       s_tdata,  // pos_x, pos_y, pixel_in, zero pad
    input  wire  [0:0]                        s_tuser,  // kind
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [47:0]                       m_tdata,  // pixel_out, source_x, source_y
    output logic [0:0]                        m_tuser   // write_enable
);

    wir_pkg::entry_t              q_entry, q_head;
    wir_pkg::queue_stat_t         q_stat;
    logic                         q_push, q_pop;
    logic [wir_pkg::PIXEL_W-1:0]  out_pixel;
    logic                         out_we;
    logic [wir_pkg::SRC_W-1:0]    out_sx, out_sy;

    wir_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser[0]),
        .in_x      (s_tdata[8:0]),
        .in_y      (s_tdata[17:9]),
        .in_pixel  (s_tdata[41:18]),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    wir_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    wir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (out_pixel),
        .out_we    (out_we),
        .out_sx    (out_sx),
        .out_sy    (out_sy)
    );

    assign m_tdata = {out_sy, out_sx, out_pixel};
    assign m_tuser = out_we;

endmodule

`default_nettype wire

FILE: sv/wir_checker.sv
// Port-level checker for the windowed image rotator, bound to the top level.
// Uses wir_pkg for the frame size.
`default_nettype none

module wir_checker (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [47:0]                      m_tdata,
    input wire [0:0]                       m_tuser
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            !m_tdata[35] && !m_tdata[47]
            && (32'(m_tdata[34:24]) < wir_pkg::FRAME_WIDTH)
            && (32'(m_tdata[46:36]) < wir_pkg::FRAME_HEIGHT))
        else $error("write flag set for a source outside the frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[35] || m_tdata[47]) |-> m_tdata[23:0] == 24'd0 && !m_tuser[0])
        else $error("pixel fetched for a negative source coordinate");

endmodule

bind windowed_image_rotator_top wir_checker u_wir_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for windowed_image_rotator_top: streams loads and rotation requests,
// predicts every fetched pixel and source position, and checks the result stream.
// Depends on wir_pkg and the RTL of the rotator only.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        logic                        kind;
        logic [wir_pkg::POS_W-1:0]   x;
        logic [wir_pkg::POS_W-1:0]   y;
        logic [wir_pkg::PIXEL_W-1:0] pixel;
    } word_t;

    typedef struct packed {
        logic [wir_pkg::PIXEL_W-1:0] pixel;
        logic                        wr;
        logic [wir_pkg::SRC_W-1:0]   sx;
        logic [wir_pkg::SRC_W-1:0]   sy;
    } fetch_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [wir_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wir_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [47:0]                    s_tdata   = '0;
    logic [0:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [47:0]                    m_tdata;
    logic [0:0]                     m_tuser;

    windowed_image_rotator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // register shadow
    logic signed [wir_pkg::TRIG_W-1:0] cos_q = wir_pkg::COS_RESET;
    logic signed [wir_pkg::TRIG_W-1:0] sin_q = '0;
    logic [wir_pkg::CTR_W-1:0]         ctr_x = '0;
    logic [wir_pkg::CTR_W-1:0]         ctr_y = '0;
    logic [wir_pkg::WIN_W-1:0]         win_l = '0;
    logic [wir_pkg::WIN_W-1:0]         win_t = '0;
    logic [wir_pkg::WIN_W-1:0]         win_r = wir_pkg::RIGHT_RESET;
    logic [wir_pkg::WIN_W-1:0]         win_b = wir_pkg::BOTTOM_RESET;

    logic [wir_pkg::PIXEL_W-1:0] frame_copy [int];
    bit                          staged [int];
    word_t                       words_to_send [$];
    fetch_t                      fetches_due [$];
    word_t                       on_offer;

    int  send_gap    = 0;
    int  rx_stall    = 0;
    int  gap_max     = 0;
    int  stall_max   = 0;
    int  mismatches  = 0;
    int  cycle_count = 0;
    bit  hold_phase  = 1'b0;
    logic rx_hold    = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic void rotate_back(input logic [wir_pkg::POS_W-1:0] x,
                                        input logic [wir_pkg::POS_W-1:0] y,
                                        output longint sx, output longint sy);
        longint dx, dy, c, s, half;
        dx   = longint'(x) - longint'(ctr_x);
        dy   = longint'(y) - longint'(ctr_y);
        c    = longint'(cos_q);
        s    = longint'(sin_q);
        half = longint'(1) <<< (wir_pkg::TRIG_FRAC_BITS - 1);
        sx = (dx * c + dy * s + (longint'(ctr_x) <<< wir_pkg::TRIG_FRAC_BITS) + half)
             >>> wir_pkg::TRIG_FRAC_BITS;
        sy = (dy * c - dx * s + (longint'(ctr_y) <<< wir_pkg::TRIG_FRAC_BITS) + half)
             >>> wir_pkg::TRIG_FRAC_BITS;
    endfunction

    function automatic bit source_in_frame(input longint sx, input longint sy);
        return sx >= 0 && sx < wir_pkg::FRAME_WIDTH && sy >= 0 && sy < wir_pkg::FRAME_HEIGHT;
    endfunction

    function automatic logic [wir_pkg::SRC_W-1:0] clamp12(input longint v);
        if (v < wir_pkg::SRC_MIN)
            return wir_pkg::SRC_W'(wir_pkg::SRC_MIN);
        if (v > wir_pkg::SRC_MAX)
            return wir_pkg::SRC_W'(wir_pkg::SRC_MAX);
        return v[wir_pkg::SRC_W-1:0];
    endfunction

    function automatic void predict_fetch(input word_t w);
        longint sx, sy;
        fetch_t f;
        bit     win_ok, in_win, in_frame;
        if (w.kind == wir_pkg::KIND_LOAD)
        begin
            frame_copy[int'(w.y) * wir_pkg::FRAME_WIDTH + int'(w.x)] = w.pixel;
            return;
        end
        rotate_back(w.x, w.y, sx, sy);
        win_ok   = win_l <= wir_pkg::FRAME_WIDTH && win_r <= wir_pkg::FRAME_WIDTH &&
                   win_t <= wir_pkg::FRAME_HEIGHT && win_b <= wir_pkg::FRAME_HEIGHT;
        in_win   = w.x >= win_l && w.x < win_r && w.y >= win_t && w.y < win_b;
        in_frame = source_in_frame(sx, sy);
        f.pixel  = in_frame ? frame_copy[int'(sy) * wir_pkg::FRAME_WIDTH + int'(sx)] : '0;
        f.wr     = win_ok && in_win && in_frame;
        f.sx     = clamp12(sx);
        f.sy     = clamp12(sy);
        fetches_due.push_back(f);
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("tb_top: mismatch on %s: got %0h, want %0h", field, got, want);
        mismatches++;
    endtask

    task automatic check_fetch(input logic [47:0] data, input logic wr);
        fetch_t want;
        if (fetches_due.size() == 0)
        begin
            flag_mismatch("unexpected result", data[23:0], '0);
            return;
        end
        want = fetches_due.pop_front();
        if (data[23:0] !== want.pixel)
            flag_mismatch("pixel_out", data[23:0], want.pixel);
        if (wr !== want.wr)
            flag_mismatch("write_enable", wr, want.wr);
        if (data[35:24] !== want.sx)
            flag_mismatch("source_x", data[35:24], want.sx);
        if (data[47:36] !== want.sy)
            flag_mismatch("source_y", data[47:36], want.sy);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_fetch(on_offer);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (words_to_send.size() > 0)
                begin
                    on_offer = words_to_send.pop_front();
                    s_tdata  <= {6'b0, on_offer.pixel, on_offer.y, on_offer.x};
                    s_tuser  <= on_offer.kind;
                    s_tvalid <= 1'b1;
                    send_gap = $urandom_range(0, gap_max);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_fetch(m_tdata, m_tuser[0]);
                rx_stall = $urandom_range(0, stall_max);
            end
            else if (rx_stall > 0)
            begin
                rx_stall = rx_stall - 1;
            end
            m_tready <= (rx_stall == 0) && !rx_hold;
        end
    end

    // long receiver hold-off
    initial
    begin
        wait (hold_phase);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic write_reg(input logic [wir_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wir_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            wir_pkg::REG_COS:          cos_q = val;
            wir_pkg::REG_SIN:          sin_q = val;
            wir_pkg::REG_CENTER_X:     ctr_x = val[wir_pkg::CTR_W-1:0];
            wir_pkg::REG_CENTER_Y:     ctr_y = val[wir_pkg::CTR_W-1:0];
            wir_pkg::REG_WINDOW_LEFT:  win_l = val[wir_pkg::WIN_W-1:0];
            wir_pkg::REG_WINDOW_TOP:   win_t = val[wir_pkg::WIN_W-1:0];
            wir_pkg::REG_WINDOW_RIGHT: win_r = val[wir_pkg::WIN_W-1:0];
            wir_pkg::REG_WINDOW_BOT:   win_b = val[wir_pkg::WIN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_rotation(input logic [15:0] c, input logic [15:0] s,
                                input logic [15:0] cx, input logic [15:0] cy);
        write_reg(wir_pkg::REG_COS, c);
        write_reg(wir_pkg::REG_SIN, s);
        write_reg(wir_pkg::REG_CENTER_X, cx);
        write_reg(wir_pkg::REG_CENTER_Y, cy);
    endtask

    task automatic set_window(input logic [15:0] l, input logic [15:0] t,
                              input logic [15:0] r, input logic [15:0] b);
        write_reg(wir_pkg::REG_WINDOW_LEFT, l);
        write_reg(wir_pkg::REG_WINDOW_TOP, t);
        write_reg(wir_pkg::REG_WINDOW_RIGHT, r);
        write_reg(wir_pkg::REG_WINDOW_BOT, b);
    endtask

    task automatic wait_drained();
        while (!(words_to_send.size() == 0 && !s_tvalid && fetches_due.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_load(input logic [wir_pkg::POS_W-1:0] x,
                              input logic [wir_pkg::POS_W-1:0] y,
                              input logic [wir_pkg::PIXEL_W-1:0] pix);
        word_t w;
        w.kind  = wir_pkg::KIND_LOAD;
        w.x     = x;
        w.y     = y;
        w.pixel = pix;
        words_to_send.push_back(w);
        staged[int'(y) * wir_pkg::FRAME_WIDTH + int'(x)] = 1'b1;
    endtask

    // load the source pixel first when it was never written
    task automatic queue_request(input logic [wir_pkg::POS_W-1:0] x,
                                 input logic [wir_pkg::POS_W-1:0] y);
        longint sx, sy;
        word_t  w;
        rotate_back(x, y, sx, sy);
        if (source_in_frame(sx, sy) &&
            !staged.exists(int'(sy) * wir_pkg::FRAME_WIDTH + int'(sx)))
            queue_load(sx[wir_pkg::POS_W-1:0], sy[wir_pkg::POS_W-1:0],
                       wir_pkg::PIXEL_W'($urandom));
        w.kind  = wir_pkg::KIND_REQUEST;
        w.x     = x;
        w.y     = y;
        w.pixel = wir_pkg::PIXEL_W'($urandom);
        words_to_send.push_back(w);
    endtask

    task automatic random_setup();
        real ang;
        int  pick;
        int  l, t, r, b;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
            set_rotation(16'($rtoi($floor($cos(ang) * 16384.0 + 0.5))),
                         16'($rtoi($floor($sin(ang) * 16384.0 + 0.5))),
                         {7'($urandom), 9'($urandom)}, {7'($urandom), 9'($urandom)});
        end
        else if (pick < 9)
        begin
            set_rotation(16'($urandom), 16'($urandom), 16'($urandom_range(0, 511)),
                         16'($urandom_range(0, 511)));
        end
        else
        begin
            set_rotation(16'h8000, 16'h7FFF, 16'd511, 16'd0);
        end
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            set_window(16'd0, 16'd0, 16'd512, 16'd512);
        end
        else if (pick < 8)
        begin
            l = $urandom_range(0, 400);
            t = $urandom_range(0, 400);
            r = $urandom_range(l, 512);
            b = $urandom_range(t, 512);
            set_window(16'(l), 16'(t), 16'(r), 16'(b));
        end
        else
        begin
            set_window({6'($urandom), 10'($urandom)}, 16'($urandom_range(0, 1023)),
                       16'($urandom_range(0, 1023)), 16'($urandom_range(513, 1023)));
        end
    endtask

    task automatic run_random_phase(input int n_req);
        for (int i = 0; i < n_req; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_load(wir_pkg::POS_W'($urandom), wir_pkg::POS_W'($urandom),
                           wir_pkg::PIXEL_W'($urandom));
            queue_request(wir_pkg::POS_W'($urandom), wir_pkg::POS_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: identity mapping over the full frame, corner pixels
        gap_max   = 15;
        stall_max = 15;
        queue_load(9'd0, 9'd0, 24'h000000);
        queue_load(9'd511, 9'd511, 24'hFFFFFF);
        queue_load(9'd0, 9'd511, 24'h5A5A5A);
        queue_load(9'd511, 9'd0, 24'hA5A5A5);
        queue_request(9'd0, 9'd0);
        queue_request(9'd511, 9'd511);
        queue_request(9'd0, 9'd511);
        queue_request(9'd511, 9'd0);
        wait_drained();

        // half turn about the middle, window edges, source leaving the frame
        set_rotation(16'hC000, 16'h0000, 16'd256, 16'd256);
        set_window(16'd10, 16'd10, 16'd500, 16'd500);
        queue_request(9'd0, 9'd0);
        queue_request(9'd5, 9'd300);
        queue_request(9'd256, 9'd256);
        queue_request(9'd499, 9'd499);
        queue_request(9'd500, 9'd10);
        wait_drained();

        // invalid window bounds
        set_window(16'd1023, 16'd0, 16'd600, 16'd512);
        queue_request(9'd256, 9'd256);
        queue_request(9'd100, 9'd200);
        wait_drained();

        // empty window
        set_window(16'd100, 16'd100, 16'd100, 16'd100);
        queue_request(9'd100, 9'd100);
        wait_drained();

        // saturation of source coordinates both ways
        set_window(16'd0, 16'd0, 16'd512, 16'd512);
        set_rotation(16'h8000, 16'h8000, 16'd511, 16'd511);
        queue_request(9'd0, 9'd0);
        queue_request(9'd0, 9'd511);
        wait_drained();
        set_rotation(16'h8000, 16'h8000, 16'd0, 16'd0);
        queue_request(9'd511, 9'd511);
        queue_request(9'd511, 9'd0);
        wait_drained();

        // back pressure: sender runs flat out while the receiver holds off
        set_rotation(16'h2D41, 16'h2D41, 16'd256, 16'd256);
        gap_max    = 0;
        stall_max  = 0;
        hold_phase = 1'b1;
        run_random_phase(60);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            random_setup();
            gap_max   = (p % 2 == 0) ? 15 : 0;
            stall_max = (p % 4 < 2) ? 15 : 0;
            run_random_phase(70);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
